// File: design/srrb_pkg.sv
package srrb_pkg;

  // Ring geometry
  localparam int RING_BYTES     = 2048;
  localparam int RECORD_RESERVE = 14;
  localparam int PTR_W          = $clog2(RING_BYTES);
  localparam int CNT_W          = 12;
  localparam int CFG_W          = 12;

  // Record framing
  localparam int REC_LEN   = 13;
  localparam int IDX_W     = $clog2(REC_LEN);
  localparam logic [7:0] SEP_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [15:0] COUNTER_INIT = 16'h0001;
  localparam logic [CFG_W-1:0] DRAIN_LEVEL_INIT = CFG_W'(512);
  localparam logic [CNT_W-1:0] PUSH_LIMIT =
    CNT_W'(RING_BYTES - RECORD_RESERVE);

  // Opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RESULT
  } srrb_state_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] sample_x;
    logic [15:0] sample_y;
    logic [15:0] sample_z;
    logic        hold;
  } srrb_in_t;

  typedef struct packed {
    logic [7:0]       byte_out;
    logic             byte_valid;
    logic             record_accepted;
    logic             record_dropped;
    logic [CNT_W-1:0] fill_level;
    logic             block_ready;
  } srrb_out_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } srrb_wr_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
  } srrb_rd_t;

  // Byte at position idx of a framed record
  function automatic logic [7:0] record_byte(input logic [IDX_W-1:0] idx,
                                             input logic [15:0] counter,
                                             input logic [15:0] sx,
                                             input logic [15:0] sy,
                                             input logic [15:0] sz);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      IDX_W'(0):  b = counter[15:8];
      IDX_W'(1):  b = counter[7:0];
      IDX_W'(2):  b = SEP_COMMA;
      IDX_W'(3):  b = sx[15:8];
      IDX_W'(4):  b = sx[7:0];
      IDX_W'(5):  b = SEP_COMMA;
      IDX_W'(6):  b = sy[15:8];
      IDX_W'(7):  b = sy[7:0];
      IDX_W'(8):  b = SEP_COMMA;
      IDX_W'(9):  b = sz[15:8];
      IDX_W'(10): b = sz[7:0];
      IDX_W'(11): b = CHAR_CR;
      IDX_W'(12): b = CHAR_LF;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  // Pointer advance with wrap at the ring end
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// File: design/srrb_ram.sv
module srrb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/srrb_ctrl.sv
module srrb_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  srrb_pkg::srrb_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srrb_pkg::srrb_out_t            out_data,
  input  logic [srrb_pkg::CFG_W-1:0]     drain_level,
  output srrb_pkg::srrb_wr_t             wr,
  output srrb_pkg::srrb_rd_t             rd,
  input  logic [7:0]                     rd_data
);

  import srrb_pkg::*;

  srrb_state_t      state, state_next;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      counter;
  logic [IDX_W-1:0] idx;
  logic [15:0]      sx, sy, sz;
  logic             pend_acc, pend_drop, pend_pop;

  logic accept, push_ok, pop_ok, write_last, load_out;

  assign accept     = in_valid && in_ready;
  assign push_ok    = (in_data.opcode == OP_PUSH) && !in_data.hold &&
                      (byte_count < PUSH_LIMIT);
  assign pop_ok     = (in_data.opcode == OP_POP) && (byte_count != '0);
  assign write_last = (idx == IDX_W'(REC_LEN - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = push_ok ? ST_WRITE : ST_RESULT;
        end
      end
      ST_WRITE: begin
        if (write_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    wr.en    = 1'b0;
    wr.addr  = wr_ptr;
    wr.data  = record_byte(idx, counter, sx, sy, sz);
    rd.en    = 1'b0;
    rd.addr  = rd_ptr;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   begin
        in_ready = 1'b1;
        rd.en    = in_valid && pop_ok;
      end
      ST_WRITE:  wr.en = 1'b1;
      ST_RESULT: load_out = !out_valid || out_ready;
      default:   ;
    endcase
  end

  // Fill count: one up per written byte, one down per popped byte
  always_comb begin
    byte_count_next = byte_count;
    if (wr.en) begin
      byte_count_next = byte_count + CNT_W'(1);
    end else if (rd.en) begin
      byte_count_next = byte_count - CNT_W'(1);
    end
  end

  // State, pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      byte_count <= '0;
      counter    <= COUNTER_INIT;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      if (wr.en) begin
        wr_ptr <= ptr_inc(wr_ptr);
        idx    <= write_last ? '0 : idx + IDX_W'(1);
        if (write_last) begin
          counter <= counter + 16'd1;
        end
      end
      if (rd.en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the item's samples and its outcome
  always_ff @(posedge clk) begin
    if (accept) begin
      sx        <= in_data.sample_x;
      sy        <= in_data.sample_y;
      sz        <= in_data.sample_z;
      pend_acc  <= push_ok;
      pend_drop <= (in_data.opcode == OP_PUSH) && !push_ok;
      pend_pop  <= pop_ok;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.byte_out        <= pend_pop ? rd_data : 8'h00;
      out_data.byte_valid      <= pend_pop;
      out_data.record_accepted <= pend_acc;
      out_data.record_dropped  <= pend_drop;
      out_data.fill_level      <= byte_count;
      out_data.block_ready     <= ({1'b0, byte_count} >= {1'b0, drain_level});
    end
  end

  // Fill never passes the ring size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(RING_BYTES))
    else $error("fill count beyond ring size");

  // Each write cycle adds exactly one byte
  a_write_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |=> byte_count == $past(byte_count) + CNT_W'(1))
    else $error("write cycle did not add one byte");

  // A pop on a non-empty ring removes one byte and advances the read pointer
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    rd.en |=> byte_count == $past(byte_count) - CNT_W'(1) &&
              rd_ptr == ptr_inc($past(rd_ptr)))
    else $error("pop did not remove one byte");

  // A result word carries at most one outcome
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_data.byte_valid, out_data.record_accepted,
                              out_data.record_dropped}) <= 1)
    else $error("result word carries more than one outcome");

  // The memory is never written and read in the same cycle
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr.en && rd.en))
    else $error("write and read issued together");

endmodule

// File: design/sample_record_ring_buffer.sv
// Push of a record: the record is written byte by byte in ST_WRITE, then the result word
//   is loaded in ST_RESULT, which waits while the output is stalled.
// Pop, dropped push or pop on an empty ring: result word loaded in ST_RESULT.
//   Words are taken only in ST_IDLE; the single byte-wide write port sets the push rate.
// Reset (rst, synchronous): pointers and fill cleared, record counter 1, block size
//   512; the ring memory itself is not cleared.
module sample_record_ring_buffer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  srrb_pkg::srrb_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srrb_pkg::srrb_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srrb_pkg::CFG_W-1:0]     cfg_data
);

  import srrb_pkg::*;

  logic [CFG_W-1:0] drain_level;
  srrb_wr_t         wr;
  srrb_rd_t         rd;
  logic [7:0]       rd_data;

  // Block size register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_level <= DRAIN_LEVEL_INIT;
    end else if (cfg_valid && cfg_ready) begin
      drain_level <= cfg_data;
    end
  end

  srrb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .drain_level (drain_level),
    .wr          (wr),
    .rd          (rd),
    .rd_data     (rd_data)
  );

  srrb_ram #(
    .DATA_W (8),
    .DEPTH  (RING_BYTES),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (rd_data)
  );

endmodule
